/* rtl/mi3_pkg.sv */
// mi3_pkg: types, widths and constants shared by the 3x3 matrix inverse core.
// Depends on nothing; compiled first.
package mi3_pkg;

    localparam int EW    = 32;   // Q16.16 element width
    localparam int THR_W = 31;   // threshold register width
    localparam int PW    = 64;   // element product width
    localparam int AW    = 65;   // cofactor width, signed
    localparam int DW    = 98;   // determinant / divider datapath width
    localparam int NQ    = 32;   // quotient bits, one per divider stage
    localparam int NE    = 9;    // elements per matrix

    typedef logic signed [EW-1:0] elem_t;
    typedef elem_t mat_t [NE];

    typedef struct packed {
        elem_t a00;
        elem_t a01;
        elem_t a02;
        elem_t a10;
        elem_t a11;
        elem_t a12;
        elem_t a20;
        elem_t a21;
        elem_t a22;
    } in_item_t;

    typedef struct packed {
        elem_t r00;
        elem_t r01;
        elem_t r02;
        elem_t r10;
        elem_t r11;
        elem_t r12;
        elem_t r20;
        elem_t r21;
        elem_t r22;
        logic  singular;
        elem_t determinant;
    } out_item_t;

    // Cofactor k = m[P]*m[Q] - m[R]*m[S] (adjugate, row-major)
    localparam int unsigned COF_P [NE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int unsigned COF_Q [NE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int unsigned COF_R [NE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int unsigned COF_S [NE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // Determinant expansion along row 0 uses these cofactors
    localparam int unsigned DET_ADJ [3] = '{0, 3, 6};

    function automatic mat_t to_mat(input in_item_t x);
        mat_t m;
        m[0] = x.a00; m[1] = x.a01; m[2] = x.a02;
        m[3] = x.a10; m[4] = x.a11; m[5] = x.a12;
        m[6] = x.a20; m[7] = x.a21; m[8] = x.a22;
        return m;
    endfunction

    // Apply sign to a magnitude and clamp to the Q16.16 range
    function automatic elem_t sat_q16(input logic neg, input logic big,
                                      input logic [EW-1:0] mag);
        elem_t r;
        if (!neg)
        begin
            if (big || mag > 32'h7FFF_FFFF) r = 32'sh7FFF_FFFF;
            else                            r = elem_t'(mag);
        end
        else
        begin
            if (big || mag > 32'h8000_0000) r = elem_t'(32'h8000_0000);
            else                            r = elem_t'(-mag);
        end
        return r;
    endfunction

endpackage

/* rtl/mi3_if.sv */
// mi3_if: valid/ready channel interfaces for matrix items in and results out.
// Depends on mi3_pkg.
interface mi3_in_if;
    logic                valid;
    logic                ready;
    mi3_pkg::in_item_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mi3_out_if;
    logic                valid;
    logic                ready;
    mi3_pkg::out_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/mi3_div.sv */
// mi3_div: pipelined restoring divider, one quotient bit per stage.
// Depends on mi3_pkg.
module mi3_div (
    input  logic                    clk,
    input  logic                    en,
    input  logic [mi3_pkg::DW-1:0]  rem_in,
    input  logic [mi3_pkg::DW-1:0]  den_in,
    input  logic [mi3_pkg::NQ-1:0]  low_in,
    output logic [mi3_pkg::NQ-1:0]  quo
);
    import mi3_pkg::*;

    logic [DW-1:0] rem_reg [NQ];
    logic [DW-1:0] den_reg [NQ];
    logic [NQ-1:0] low_reg [NQ];
    logic [NQ-1:0] quo_reg [NQ];

    for (genvar k = 0; k < NQ; k++)
    begin : g_st
        logic [DW-1:0] r_prev;
        logic [DW-1:0] d_prev;
        logic [NQ-1:0] l_prev;
        logic [NQ-1:0] q_prev;
        logic [DW-1:0] sh;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign r_prev = rem_in;
            assign d_prev = den_in;
            assign l_prev = low_in;
            assign q_prev = '0;
        end
        else
        begin : g_next
            assign r_prev = rem_reg[k-1];
            assign d_prev = den_reg[k-1];
            assign l_prev = low_reg[k-1];
            assign q_prev = quo_reg[k-1];
        end

        // partial remainder stays below the divisor, so the top bit is free
        assign sh = {r_prev[DW-2:0], l_prev[NQ-1]};
        assign ge = (sh >= d_prev);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? (sh - d_prev) : sh;
                den_reg[k] <= d_prev;
                low_reg[k] <= {l_prev[NQ-2:0], 1'b0};
                quo_reg[k] <= {q_prev[NQ-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[NQ-1];

endmodule

/* rtl/matrix3_inverse_core.sv */
// matrix3_inverse_core: 3x3 Q16.16 matrix inverse by adjugate / determinant.
// Depends on mi3_pkg, mi3_if (channels) and mi3_div (quotient pipeline).
//
//   channel    dir  handshake       payload
//   mat_in     in   valid/ready     a00..a22, Q16.16 signed
//   inv_out    out  valid/ready     r00..r22, singular, determinant
//   cfg        in   cfg_we          cfg_wdata = singular_threshold
//
// One item per cycle sustained while the skid register is empty.
// Stages: products, cofactors, det partials, det terms, det sum, |det|,
// numerators/rounding/singular test, overflow test, then 32 divider stages.
// Reset clears valid bits, the output/skid flags and the threshold.
// A stalled output fills the skid register; the pipeline then freezes whole
// and input ready drops until the skid empties. Nothing is dropped or repeated.
module matrix3_inverse_core (
    input  logic                       clk,
    input  logic                       rst_n,
    mi3_in_if.sink                     mat_in,
    mi3_out_if.source                  inv_out,
    input  logic                       cfg_we,
    input  logic [mi3_pkg::THR_W-1:0]  cfg_wdata
);
    import mi3_pkg::*;

    localparam int NPRE = 8;            // stages ahead of the divider
    localparam int NS   = NPRE + NQ;    // valid line length

    typedef struct packed {
        in_item_t        a;
        logic            sing;
        elem_t           detq;
        logic [NE-1:0]   negq;
        logic [NE-1:0]   ovf;
    } side_t;

    // ---------------- control ----------------
    logic          run;
    logic          take;
    logic [NS-1:0] v_reg;
    logic [THR_W-1:0] thr_reg;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_data_reg, out_data_next;
    out_item_t skid_data_reg, skid_data_next;

    // whole pipeline moves together; it only stops once the skid holds an item
    assign run          = !skid_valid_reg;
    assign mat_in.ready = run;
    assign take         = mat_in.valid && run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            thr_reg <= '0;
        end
        else
        begin
            if (run)
                v_reg <= {v_reg[NS-2:0], take};
            if (cfg_we)
                thr_reg <= cfg_wdata;
        end
    end

    // ---------------- stage 1: element products ----------------
    mat_t m_in;
    assign m_in = to_mat(mat_in.data);

    logic signed [PW-1:0] pa_reg [NE];
    logic signed [PW-1:0] pb_reg [NE];
    in_item_t             a1_reg;

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            for (int i = 0; i < NE; i++)
            begin
                pa_reg[i] <= m_in[COF_P[i]] * m_in[COF_Q[i]];
                pb_reg[i] <= m_in[COF_R[i]] * m_in[COF_S[i]];
            end
            a1_reg <= mat_in.data;
        end
    end

    // ---------------- stage 2: cofactors ----------------
    logic signed [AW-1:0] adj_reg [NE];
    in_item_t             a2_reg;

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            for (int i = 0; i < NE; i++)
                adj_reg[i] <= AW'(pa_reg[i]) - AW'(pb_reg[i]);
            a2_reg <= a1_reg;
        end
    end

    // ---------------- stage 3: det partial products, |adj| ----------------
    mat_t m2;
    assign m2 = to_mat(a2_reg);

    logic signed [AW-1:0] pl_reg [3];
    logic signed [AW-1:0] ph_reg [3];
    logic [PW-1:0]        aadj3_reg [NE];
    logic [NE-1:0]        aneg3_reg;
    in_item_t             a3_reg;

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            for (int k = 0; k < 3; k++)
            begin
                // 65-bit cofactor split into unsigned low and signed high halves
                pl_reg[k] <= m2[k] * $signed({1'b0, adj_reg[DET_ADJ[k]][31:0]});
                ph_reg[k] <= m2[k] * $signed(adj_reg[DET_ADJ[k]][AW-1:32]);
            end
            for (int i = 0; i < NE; i++)
            begin
                aadj3_reg[i] <= adj_reg[i][AW-1] ? PW'(-adj_reg[i]) : PW'(adj_reg[i]);
                aneg3_reg[i] <= adj_reg[i][AW-1];
            end
            a3_reg <= a2_reg;
        end
    end

    // ---------------- stage 4: det terms ----------------
    logic signed [DW-1:0] term_reg [3];
    logic [PW-1:0]        aadj4_reg [NE];
    logic [NE-1:0]        aneg4_reg;
    in_item_t             a4_reg;

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            for (int k = 0; k < 3; k++)
                term_reg[k] <= (DW'(ph_reg[k]) <<< 32) + DW'(pl_reg[k]);
            aadj4_reg <= aadj3_reg;
            aneg4_reg <= aneg3_reg;
            a4_reg    <= a3_reg;
        end
    end

    // ---------------- stage 5: det sum (Q48.48, exact) ----------------
    logic signed [DW-1:0] det_reg;
    logic [PW-1:0]        aadj5_reg [NE];
    logic [NE-1:0]        aneg5_reg;
    in_item_t             a5_reg;

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            det_reg   <= term_reg[0] + term_reg[1] + term_reg[2];
            aadj5_reg <= aadj4_reg;
            aneg5_reg <= aneg4_reg;
            a5_reg    <= a4_reg;
        end
    end

    // ---------------- stage 6: |det| ----------------
    logic [DW-1:0] dmag_reg;
    logic          dneg_reg;
    logic [PW-1:0] aadj6_reg [NE];
    logic [NE-1:0] aneg6_reg;
    in_item_t      a6_reg;

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            dneg_reg  <= det_reg[DW-1];
            dmag_reg  <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            aadj6_reg <= aadj5_reg;
            aneg6_reg <= aneg5_reg;
            a6_reg    <= a5_reg;
        end
    end

    // ---------------- stage 7: numerators, det rounding, singular test ----------------
    logic [DW-1:0] rd;
    assign rd = dmag_reg + DW'(64'h8000_0000);

    logic [DW-1:0] num_reg [NE];
    logic [DW-1:0] den7_reg;
    logic [NE-1:0] negq7_reg;
    logic          sing7_reg;
    elem_t         detq7_reg;
    in_item_t      a7_reg;

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            // round(|adj| * 2^32 / |det|) = floor((|adj|*2^33 + |det|) / (2|det|))
            for (int i = 0; i < NE; i++)
            begin
                num_reg[i]   <= (DW'(aadj6_reg[i]) << 33) + dmag_reg;
                negq7_reg[i] <= aneg6_reg[i] ^ dneg_reg;
            end
            den7_reg  <= dmag_reg << 1;
            sing7_reg <= (DW'({thr_reg, 32'h0}) >= dmag_reg);
            detq7_reg <= sat_q16(dneg_reg, |rd[DW-1:64], rd[63:32]);
            a7_reg    <= a6_reg;
        end
    end

    // ---------------- stage 8: quotient overflow, divider load ----------------
    logic [DW-1:0] rem8_reg [NE];
    logic [NQ-1:0] low8_reg [NE];
    logic [DW-1:0] den8_reg;
    side_t         side_reg [NQ+1];

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            for (int i = 0; i < NE; i++)
            begin
                // quotient of 2^32 or more saturates whatever its sign
                side_reg[0].ovf[i] <= (DW'(num_reg[i] >> 32) >= den7_reg);
                rem8_reg[i]        <= DW'(num_reg[i] >> 32);
                low8_reg[i]        <= num_reg[i][NQ-1:0];
            end
            den8_reg           <= den7_reg;
            side_reg[0].a      <= a7_reg;
            side_reg[0].sing   <= sing7_reg;
            side_reg[0].detq   <= detq7_reg;
            side_reg[0].negq   <= negq7_reg;
            for (int s = 1; s <= NQ; s++)
                side_reg[s] <= side_reg[s-1];
        end
    end

    // ---------------- divider pipelines, one per element ----------------
    logic [NQ-1:0] quo [NE];

    for (genvar e = 0; e < NE; e++)
    begin : g_div
        mi3_div u_div (
            .clk    (clk),
            .en     (run),
            .rem_in (rem8_reg[e]),
            .den_in (den8_reg),
            .low_in (low8_reg[e]),
            .quo    (quo[e])
        );
    end

    // ---------------- result assembly ----------------
    side_t     fs;
    mat_t      fa;
    elem_t     fr [NE];
    out_item_t fin;
    logic      fin_valid;

    assign fs        = side_reg[NQ];
    assign fa        = to_mat(fs.a);
    assign fin_valid = v_reg[NS-1] && run;

    always_comb
    begin
        for (int i = 0; i < NE; i++)
            fr[i] = fs.sing ? fa[i] : sat_q16(fs.negq[i], fs.ovf[i], quo[i]);
        fin.r00 = fr[0]; fin.r01 = fr[1]; fin.r02 = fr[2];
        fin.r10 = fr[3]; fin.r11 = fr[4]; fin.r12 = fr[5];
        fin.r20 = fr[6]; fin.r21 = fr[7]; fin.r22 = fr[8];
        fin.singular    = fs.sing;
        fin.determinant = fs.detq;
    end

    // ---------------- output register with skid ----------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || inv_out.ready)
        begin
            out_valid_next  = skid_valid_reg || fin_valid;
            out_data_next   = skid_valid_reg ? skid_data_reg : fin;
            skid_valid_next = 1'b0;
        end
        else if (fin_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign inv_out.valid = out_valid_reg;
    assign inv_out.data  = out_data_reg;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output register is empty");

    a_skid_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !mat_in.ready)
        else $error("input accepted while skid register is full");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !inv_out.ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result lost or changed");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(v_reg))
        else $error("pipeline moved while skid was full");

endmodule
